// ===== rtl/mse_pkg.sv =====
// Package for the MIPS subset execute unit: command codes, payload structs,
// queue entry, back-end state type and sizing constants. No dependencies.
package mse_pkg;

  localparam int unsigned MEM_WORDS_DEFAULT = 4096;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned REG_COUNT         = 32;

  localparam logic [3:0] CMD_ADD      = 4'd0;
  localparam logic [3:0] CMD_SUB      = 4'd1;
  localparam logic [3:0] CMD_SLL      = 4'd2;
  localparam logic [3:0] CMD_SRL      = 4'd3;
  localparam logic [3:0] CMD_SW       = 4'd4;
  localparam logic [3:0] CMD_LW       = 4'd5;
  localparam logic [3:0] CMD_PRELOAD  = 4'd6;
  localparam logic [3:0] CMD_READ_REG = 4'd7;
  localparam logic [3:0] CMD_READ_MEM = 4'd8;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_SLL,
    OP_SRL,
    OP_SW,
    OP_LW,
    OP_PRELOAD,
    OP_READ_REG,
    OP_READ_MEM,
    OP_NONE
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_MEM
  } state_e;

  typedef struct packed {
    logic        [3:0]  cmd;
    logic        [4:0]  target_reg;
    logic        [4:0]  source_reg;
    logic        [4:0]  second_reg;
    logic        [4:0]  shift_amount;
    logic signed [15:0] offset;
    logic signed [31:0] data_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               reg_written;
    logic        [4:0]  written_reg;
    logic               address_error;
  } out_t;

  // Classified word as it waits between front and back
  typedef struct packed {
    op_e                op;
    logic        [4:0]  rd;
    logic        [4:0]  ra;
    logic        [4:0]  rb;
    logic        [4:0]  sh;
    logic signed [15:0] offset;
    logic signed [31:0] data_value;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// ===== rtl/mse_front.sv =====
// Front end of the MIPS subset execute unit: accepts input words, classifies
// the command and holds classified words in a short queue. Uses mse_pkg.
module mse_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mse_pkg::in_t        in_data_i,
  input  mse_pkg::back_stat_t stat_i,
  output logic                q_valid_o,
  output mse_pkg::entry_t     q_entry_o,
  input  logic                q_pop_i
);
  import mse_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t            fifo_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  entry_t            entry;
  logic              push;
  logic              full;

  always_comb begin
    entry.rd         = in_data_i.target_reg;
    entry.ra         = in_data_i.source_reg;
    entry.rb         = in_data_i.second_reg;
    entry.sh         = in_data_i.shift_amount;
    entry.offset     = in_data_i.offset;
    entry.data_value = in_data_i.data_value;
    case (in_data_i.cmd)
      CMD_ADD:      entry.op = OP_ADD;
      CMD_SUB:      entry.op = OP_SUB;
      CMD_SLL:      entry.op = OP_SLL;
      CMD_SRL:      entry.op = OP_SRL;
      CMD_SW:       entry.op = OP_SW;
      CMD_LW:       entry.op = OP_LW;
      CMD_PRELOAD:  entry.op = OP_PRELOAD;
      CMD_READ_REG: entry.op = OP_READ_REG;
      CMD_READ_MEM: entry.op = OP_READ_MEM;
      default:      entry.op = OP_NONE;
    endcase
    // store data and read-back both come through the second read port
    if (entry.op == OP_SW || entry.op == OP_READ_REG) begin
      entry.rb = in_data_i.target_reg;
    end
  end

  assign full       = (count_q == CntW'(QUEUE_DEPTH));
  assign in_ready_o = !full && !stat_i.clearing;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ===== rtl/mse_regfile.sv =====
// Register file of the MIPS subset execute unit: 32 words, two registered
// read ports, one write port, per-entry valid bits for reset. Uses mse_pkg.
module mse_regfile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_en_i,
  input  logic [4:0]  ra_addr_i,
  input  logic [4:0]  rb_addr_i,
  output logic [31:0] ra_data_o,
  output logic [31:0] rb_data_o,
  input  logic        wr_en_i,
  input  logic [4:0]  wr_addr_i,
  input  logic [31:0] wr_data_i
);
  import mse_pkg::*;

  logic [31:0]          regs_q [REG_COUNT];
  logic [REG_COUNT-1:0] valid_q;
  logic [31:0]          ra_q, rb_q;
  logic                 ra_vld_q, rb_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      ra_vld_q <= 1'b0;
      rb_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        ra_vld_q <= valid_q[ra_addr_i];
        rb_vld_q <= valid_q[rb_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      regs_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      ra_q <= regs_q[ra_addr_i];
      rb_q <= regs_q[rb_addr_i];
    end
  end

  // an entry never written since reset reads as zero
  assign ra_data_o = ra_vld_q ? ra_q : '0;
  assign rb_data_o = rb_vld_q ? rb_q : '0;

endmodule

// ===== rtl/mse_back.sv =====
// Back end of the MIPS subset execute unit: sequencer, ALU, address check,
// data memory with clearing pass, and output register. Uses mse_pkg, mse_regfile.
module mse_back #(
  parameter int unsigned MemWords = mse_pkg::MEM_WORDS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  mse_pkg::entry_t     q_entry_i,
  output logic                q_pop_o,
  output mse_pkg::back_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mse_pkg::out_t       out_data_o
);
  import mse_pkg::*;

  localparam int unsigned AddrW = $clog2(MemWords);

  state_e           state_q, state_d;
  entry_t           cur_q;
  logic [AddrW-1:0] clr_cnt_q;
  logic [31:0]      dmem_q [MemWords];
  logic [31:0]      mem_rdata_q;
  logic             out_valid_q;
  out_t             out_q;

  logic [31:0]      ra_data, rb_data;
  logic [31:0]      base;
  logic [32:0]      addr_sum;
  logic             addr_ok;
  logic             out_free;
  logic             clear_done;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr;
  logic [31:0]      mem_wdata;
  logic             res_load;
  out_t             res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign clear_done = (clr_cnt_q == AddrW'(MemWords - 1));

  // word address: base register (sw, lw) or zero, plus sign-extended offset, no wrap
  assign base     = (cur_q.op == OP_SW || cur_q.op == OP_LW) ? ra_data : '0;
  assign addr_sum = {base[31], base} + {{17{cur_q.offset[15]}}, cur_q.offset};
  assign addr_ok  = !addr_sum[32] && (addr_sum < 33'(MemWords));

  mse_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (q_pop_o),
    .ra_addr_i (q_entry_i.ra),
    .rb_addr_i (q_entry_i.rb),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data),
    .wr_en_i   (res_load && res.reg_written),
    .wr_addr_i (cur_q.rd),
    .wr_data_i (res.result_value)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = mem_re ? ST_MEM : ST_IDLE;
      end
      ST_MEM: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = addr_sum[AddrW-1:0];
    mem_wdata = (cur_q.op == OP_SW) ? rb_data : cur_q.data_value;
    res_load  = 1'b0;
    res       = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        q_pop_o = q_valid_i && out_free;
      end
      ST_EXEC: begin
        mem_we   = (cur_q.op == OP_SW || cur_q.op == OP_PRELOAD) && addr_ok;
        mem_re   = (cur_q.op == OP_LW || cur_q.op == OP_READ_MEM) && addr_ok;
        res_load = !mem_re;
        case (cur_q.op)
          OP_ADD: begin
            res.result_value = ra_data + rb_data;
            res.reg_written  = 1'b1;
          end
          OP_SUB: begin
            res.result_value = ra_data - rb_data;
            res.reg_written  = 1'b1;
          end
          OP_SLL: begin
            res.result_value = ra_data << cur_q.sh;
            res.reg_written  = 1'b1;
          end
          OP_SRL: begin
            res.result_value = ra_data >> cur_q.sh;
            res.reg_written  = 1'b1;
          end
          OP_SW: begin
            res.result_value = addr_ok ? rb_data : '0;
            res.address_error = !addr_ok;
          end
          OP_PRELOAD: begin
            res.result_value = addr_ok ? cur_q.data_value : '0;
            res.address_error = !addr_ok;
          end
          OP_READ_REG: begin
            res.result_value = rb_data;
          end
          OP_LW, OP_READ_MEM: begin
            res.address_error = !addr_ok;
          end
          default: begin
            res = '0;
          end
        endcase
        res.written_reg = res.reg_written ? cur_q.rd : '0;
      end
      ST_MEM: begin
        res_load         = 1'b1;
        res.result_value = mem_rdata_q;
        res.reg_written  = (cur_q.op == OP_LW);
        res.written_reg  = res.reg_written ? cur_q.rd : '0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_entry_i;
    end
    if (res_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dmem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= dmem_q[addr_sum[AddrW-1:0]];
    end
  end

  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// ===== rtl/mips_subset_execute_unit.sv =====
// MIPS subset execute unit, top level: joins front end, queue and back end.
// Depends on mse_pkg, mse_front, mse_back.
//
// Executes one decoded instruction or service command per input word and
// returns one result word for each. The front end queues up to two words, so
// input is taken while the back end works or a result waits. The back end
// handles one word at a time and takes the next only while the output
// register is free: register file read, then execute for register and ALU
// commands; lw and read mem with an in-range address add the synchronous
// data memory read. After reset a clearing pass writes zero to every data
// memory word, during which in_ready_o stays low.
module mips_subset_execute_unit #(
  parameter int unsigned MemWords = mse_pkg::MEM_WORDS_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mse_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mse_pkg::out_t out_data_o
);
  import mse_pkg::*;

  back_stat_t stat;
  logic       q_valid;
  entry_t     q_entry;
  logic       q_pop;

  mse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .stat_i     (stat),
    .q_valid_o  (q_valid),
    .q_entry_o  (q_entry),
    .q_pop_i    (q_pop)
  );

  mse_back #(
    .MemWords (MemWords)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/mse_checker.sv =====
// Port-level checker for the MIPS subset execute unit, bound to the top level.
// Depends on mse_pkg and mips_subset_execute_unit.
module mse_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input mse_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mse_pkg::out_t out_data_o
);
  import mse_pkg::*;

  logic [3:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // count words accepted whose result is not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != '0))
    else $error("result word without an accepted input word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  a_written_reg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.reg_written |-> (out_data_o.written_reg == '0))
    else $error("written_reg set without a register write");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.address_error |->
      (out_data_o.result_value == '0) && !out_data_o.reg_written)
    else $error("address error with a value or register write");

endmodule

bind mips_subset_execute_unit mse_checker u_checker (.*);

// ===== verif/tb_mips_subset_execute_unit.sv =====
// Testbench for mips_subset_execute_unit: a directed opening, then random instruction
// sequences, with a local register file and memory predicting every result word.
// Depends on mse_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_mips_subset_execute_unit;
  import mse_pkg::*;

  localparam int unsigned MEM_WORDS      = MEM_WORDS_DEFAULT;
  localparam int          RANDOM_WORDS   = 1350;
  localparam int          QUIET_TAIL     = 150;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam logic [3:0]  CMD_UNDEF_LO   = 4'd9;
  localparam logic [3:0]  CMD_UNDEF_HI   = 4'd15;

  typedef struct {
    in_t word;
    bit  drain;
  } pend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  pend_t       word_fifo[$];
  out_t        result_fifo[$];
  logic [31:0] reg_file[REG_COUNT];
  logic [31:0] data_mem[MEM_WORDS];
  int          live_count = 0;
  int          fail_count = 0;
  int          gap_left;
  int          gap_pct = 0;
  int          words_taken = 0;
  int          stall_left;
  int          stall_pct = 0;
  int          mon_cycles = 0;
  int          idle_cycles = 0;
  bit          quiet;

  mips_subset_execute_unit #(
    .MemWords(MEM_WORDS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic in_t mk(logic [3:0] cmd, int rt, int rs, int r2, int sh, int off,
                             logic [31:0] data);
    in_t w;
    w.cmd          = cmd;
    w.target_reg   = rt[4:0];
    w.source_reg   = rs[4:0];
    w.second_reg   = r2[4:0];
    w.shift_amount = sh[4:0];
    w.offset       = off[15:0];
    w.data_value   = data;
    return w;
  endfunction

  task automatic queue_word(in_t w, bit drain = 1'b0);
    pend_t p;
    p.word  = w;
    p.drain = drain;
    word_fifo.insert(word_fifo.size(), p);
    if (w.cmd <= CMD_READ_MEM) live_count++;
  endtask

  function automatic bit in_mem(longint a);
    return a >= 0 && a < longint'(MEM_WORDS);
  endfunction

  // Execute one word against the local register file and memory
  function automatic out_t exec_word(in_t w);
    out_t        r;
    longint      addr;
    logic [31:0] v;
    bit          wr;
    bit          err;
    v    = '0;
    wr   = 1'b0;
    err  = 1'b0;
    addr = longint'($signed(reg_file[w.source_reg])) + longint'($signed(w.offset));
    case (w.cmd)
      CMD_ADD: begin
        v  = reg_file[w.source_reg] + reg_file[w.second_reg];
        wr = 1'b1;
      end
      CMD_SUB: begin
        v  = reg_file[w.source_reg] - reg_file[w.second_reg];
        wr = 1'b1;
      end
      CMD_SLL: begin
        v  = reg_file[w.source_reg] << w.shift_amount;
        wr = 1'b1;
      end
      CMD_SRL: begin
        v  = reg_file[w.source_reg] >> w.shift_amount;
        wr = 1'b1;
      end
      CMD_SW: begin
        if (in_mem(addr)) begin
          v              = reg_file[w.target_reg];
          data_mem[addr] = v;
        end else err = 1'b1;
      end
      CMD_LW: begin
        if (in_mem(addr)) begin
          v  = data_mem[addr];
          wr = 1'b1;
        end else err = 1'b1;
      end
      CMD_PRELOAD: begin
        if (in_mem(longint'($signed(w.offset)))) begin
          data_mem[$signed(w.offset)] = w.data_value;
          v                           = w.data_value;
        end else err = 1'b1;
      end
      CMD_READ_REG: v = reg_file[w.target_reg];
      CMD_READ_MEM: begin
        if (in_mem(longint'($signed(w.offset)))) v = data_mem[$signed(w.offset)];
        else err = 1'b1;
      end
      default: ;
    endcase
    if (wr) reg_file[w.target_reg] = v;
    r.result_value  = v;
    r.reg_written   = wr;
    r.written_reg   = wr ? w.target_reg : 5'd0;
    r.address_error = err;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Driver: present queued words, idle in bursts, hold before drain-marked words
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    bit    took;
    pend_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_left   <= 0;
      quiet      <= 1'b0;
    end else begin
      took = in_valid_i && in_ready_o;
      quiet <= word_fifo.size() < QUIET_TAIL;
      if (took) begin
        result_fifo.insert(result_fifo.size(), exec_word(in_data_i));
        words_taken++;
        if (words_taken % 64 == 0) begin
          case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 8;
            default: gap_pct = 30;
          endcase
        end
      end
      if (took || !in_valid_i) begin
        if (took && !quiet && $urandom_range(0, 99) < gap_pct) begin
          gap_left   <= $urandom_range(1, 14);
          in_valid_i <= 1'b0;
        end else if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (word_fifo.size() != 0 &&
                     !(word_fifo[0].drain && result_fifo.size() != 0)) begin
          nxt = word_fifo.pop_front();
          in_data_i  <= nxt.word;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction, stall in bursts
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: result word with none expected, actual %h", $time, out_data_o);
          fail_count++;
        end else begin
          want = result_fifo.pop_front();
          check_field("result_value", want.result_value, out_data_o.result_value);
          check_field("reg_written", want.reg_written, out_data_o.reg_written);
          check_field("written_reg", want.written_reg, out_data_o.written_reg);
          check_field("address_error", want.address_error, out_data_o.address_error);
        end
      end
      mon_cycles++;
      if (mon_cycles % 200 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 3;
          default: stall_pct = 15;
        endcase
      end
      if (stall_left > 1) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (stall_left == 1) begin
        stall_left  <= 0;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        stall_left  <= $urandom_range(1, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("mips_subset_execute_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          start;
    int          seq;
    int          pick;
    int          n;
    int          z;
    int          b;
    int          x;
    int          y;
    int          rt;
    int          a;
    int          a2;
    int          k;
    int          t;
    bit          pause;
    logic [3:0]  c;
    logic [31:0] d;
    logic [95:0] raw;

    foreach (reg_file[i]) reg_file[i] = '0;
    foreach (data_mem[i]) data_mem[i] = '0;

    // Directed: empty state, address bounds, wrap, shift extremes, writable r0
    queue_word(mk(CMD_READ_REG, 0, 0, 0, 0, 0, 0));
    queue_word(mk(CMD_READ_MEM, 0, 0, 0, 0, 0, 0));
    queue_word(mk(CMD_PRELOAD, 0, 0, 0, 0, MEM_WORDS - 1, 32'h7fff_ffff));
    queue_word(mk(CMD_PRELOAD, 0, 0, 0, 0, MEM_WORDS, 32'h1234_5678));
    queue_word(mk(CMD_PRELOAD, 0, 0, 0, 0, -32768, 32'hdead_beef));
    queue_word(mk(CMD_PRELOAD, 0, 0, 0, 0, 0, 32'h8000_0000));
    queue_word(mk(CMD_READ_MEM, 0, 0, 0, 0, MEM_WORDS - 1, 0));
    queue_word(mk(CMD_READ_MEM, 0, 0, 0, 0, -1, 0));
    queue_word(mk(CMD_SUB, 0, 0, 0, 0, 0, 0));
    queue_word(mk(CMD_LW, 1, 0, 0, 0, MEM_WORDS - 1, 0));
    queue_word(mk(CMD_LW, 2, 0, 0, 0, 0, 0));
    queue_word(mk(CMD_ADD, 3, 1, 1, 0, 0, 0));
    queue_word(mk(CMD_SUB, 4, 2, 1, 0, 0, 0));
    queue_word(mk(CMD_SLL, 5, 1, 0, 31, 0, 0));
    queue_word(mk(CMD_SRL, 7, 2, 0, 31, 0, 0));
    queue_word(mk(CMD_SRL, 8, 2, 0, 0, 0, 0));
    queue_word(mk(CMD_SW, 2, 0, 0, 0, -1, 0));
    queue_word(mk(CMD_LW, 9, 0, 0, 0, 32767, 0));
    queue_word(mk(CMD_SLL, 31, 1, 0, 1, 0, 0));
    queue_word(mk(CMD_SW, 31, 0, 0, 0, 5, 0));
    queue_word(mk(CMD_READ_MEM, 0, 0, 0, 0, 5, 0));
    queue_word(mk(CMD_UNDEF_LO, 31, 31, 31, 31, -1, 32'hffff_ffff));
    queue_word(mk(CMD_UNDEF_HI, 1, 2, 3, 4, 5, 32'h0000_0001));
    // r0 is writable; base near the top must not wrap back into memory
    queue_word(mk(CMD_ADD, 0, 1, 0, 0, 0, 0));
    queue_word(mk(CMD_LW, 10, 0, 0, 0, -32768, 0));
    queue_word(mk(CMD_SW, 1, 2, 0, 0, 32767, 0));

    start = live_count;
    seq   = 0;
    while (live_count - start < RANDOM_WORDS) begin
      pause = (seq % 40 == 0);
      seq++;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // Base register from memory, then stores and loads around it
        z = $urandom_range(0, 31);
        b = (z + 1 + $urandom_range(0, 30)) % 32;
        a = $urandom_range(0, MEM_WORDS - 1);
        k = $urandom_range(0, MEM_WORDS - 1);
        queue_word(mk(CMD_SUB, z, z, z, $urandom_range(0, 31), $urandom, $urandom), pause);
        queue_word(mk(CMD_PRELOAD, $urandom_range(0, 31), 0, 0, 0, a, k));
        queue_word(mk(CMD_LW, b, z, $urandom_range(0, 31), 0, a, $urandom));
        n = $urandom_range(1, 5);
        repeat (n) begin
          if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 3))
              0:       t = -1;
              1:       t = MEM_WORDS;
              2:       t = 0;
              default: t = MEM_WORDS - 1;
            endcase
          end else begin
            t = $urandom_range(0, MEM_WORDS - 1);
          end
          rt = (b + 1 + $urandom_range(0, 30)) % 32;
          c  = $urandom_range(0, 1) ? CMD_SW : CMD_LW;
          queue_word(mk(c, rt, b, $urandom_range(0, 31), $urandom_range(0, 31), t - k,
                        $urandom));
        end
        if ($urandom_range(0, 1)) queue_word(mk(CMD_READ_MEM, 0, 0, 0, 0, t, 0));
        else queue_word(mk(CMD_READ_REG, rt, 0, 0, 0, 0, 0));
      end else if (pick < 80) begin
        // Load operands from preloaded words, then a run of ALU operations
        z  = $urandom_range(0, 31);
        x  = $urandom_range(0, 31);
        y  = $urandom_range(0, 31);
        a  = $urandom_range(0, MEM_WORDS - 1);
        a2 = $urandom_range(0, MEM_WORDS - 1);
        queue_word(mk(CMD_SUB, z, z, z, 0, 0, 0), pause);
        repeat (2) begin
          case ($urandom_range(0, 4))
            0:       d = 32'h8000_0000;
            1:       d = 32'h7fff_ffff;
            2:       d = 32'hffff_ffff;
            default: d = $urandom;
          endcase
          queue_word(mk(CMD_PRELOAD, 0, 0, 0, 0, a, d));
          a = a2;
        end
        queue_word(mk(CMD_LW, x, z, 0, 0, $urandom_range(0, 1) ? a : a2, 0));
        queue_word(mk(CMD_LW, y, z, 0, 0, a2, 0));
        n = $urandom_range(2, 6);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0:       c = CMD_ADD;
            1:       c = CMD_SUB;
            2:       c = CMD_SLL;
            default: c = CMD_SRL;
          endcase
          rt = $urandom_range(0, 31);
          queue_word(mk(c, rt, $urandom_range(0, 1) ? x : $urandom_range(0, 31),
                        $urandom_range(0, 1) ? y : $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom, $urandom));
        end
        queue_word(mk(CMD_READ_REG, rt, $urandom_range(0, 31), 0, 0, 0, 0));
      end else begin
        // Noise: every field random, undefined commands included
        n = $urandom_range(1, 3);
        repeat (n) begin
          raw = {$urandom, $urandom, $urandom};
          queue_word(in_t'(raw[$bits(in_t)-1:0]), pause);
          pause = 1'b0;
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_fifo.size() != 0 || in_valid_i) @(posedge clk_i);
    while (result_fifo.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("mips_subset_execute_unit test passed");
    end else begin
      $display("mips_subset_execute_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mse_pkg.sv
rtl/mse_front.sv
rtl/mse_regfile.sv
rtl/mse_back.sv
rtl/mips_subset_execute_unit.sv
rtl/mse_checker.sv
verif/tb_mips_subset_execute_unit.sv
